// ----- design/gptc_pkg.sv -----
package gptc_pkg;

  // fixed table geometry
  localparam int unsigned NUM_ENTRIES  = 96;
  localparam int unsigned ENTRY_BYTES  = 128;
  localparam int unsigned HEADER_BYTES = 92;
  localparam int unsigned POS_W        = 15;

  localparam logic [POS_W-1:0] POS_MAX     = {POS_W{1'b1}};
  localparam logic [POS_W-1:0] HDR_LEN     = POS_W'(HEADER_BYTES);
  localparam logic [POS_W-1:0] ENTRIES_LEN = POS_W'(NUM_ENTRIES * ENTRY_BYTES);

  localparam logic [31:0] CRC_POLY     = 32'hedb88320;
  localparam logic [31:0] CRC_INIT     = 32'hffffffff;
  localparam logic [63:0] FIRST_USABLE = 64'd6;
  localparam logic [63:0] PRIMARY_LBA  = 64'd1;

  // status codes
  localparam logic [3:0] ST_OK          = 4'd0;
  localparam logic [3:0] ST_SIGNATURE   = 4'd1;
  localparam logic [3:0] ST_HDR_SIZE    = 4'd2;
  localparam logic [3:0] ST_OWN_LBA     = 4'd3;
  localparam logic [3:0] ST_OTHER_LBA   = 4'd4;
  localparam logic [3:0] ST_FIRST_USE   = 4'd5;
  localparam logic [3:0] ST_LAST_USE    = 4'd6;
  localparam logic [3:0] ST_ENTRY_COUNT = 4'd7;
  localparam logic [3:0] ST_ENTRY_SIZE  = 4'd8;
  localparam logic [3:0] ST_HDR_CRC     = 4'd9;
  localparam logic [3:0] ST_ENTRIES_LOC = 4'd10;
  localparam logic [3:0] ST_SHORT_HDR   = 4'd11;
  localparam logic [3:0] ST_ENTRIES_CRC = 4'd12;
  localparam logic [3:0] ST_ENTRIES_LEN = 4'd13;

  // register indexes
  localparam logic [1:0] CFG_DISK_SECTORS = 2'd0;
  localparam logic [1:0] CFG_HEADER_LBA   = 2'd1;
  localparam logic [1:0] CFG_ALLOW_STALE  = 2'd2;

  localparam logic [63:0] DISK_SECTORS_RST = 64'd713728;

  // region kinds
  localparam logic ACT_HEADER  = 1'b0;
  localparam logic ACT_ENTRIES = 1'b1;

  typedef struct packed {
    logic       action;
    logic [7:0] data_byte;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    logic        region_done;
    logic [3:0]  status;
    logic [63:0] entries_location;
    logic [31:0] computed_crc;
  } result_t;

  typedef struct packed {
    logic [63:0] disk_sectors;
    logic [63:0] header_sector;
    logic        accept_stale_crc;
  } cfg_t;

  // reflected crc-32, one byte
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
    end
    return c;
  endfunction

  // signature "EFI PART"
  function automatic logic [7:0] sig_byte(input logic [2:0] p);
    logic [7:0] v;
    case (p)
      3'd0: v = 8'h45;
      3'd1: v = 8'h46;
      3'd2: v = 8'h49;
      3'd3: v = 8'h20;
      3'd4: v = 8'h50;
      3'd5: v = 8'h41;
      3'd6: v = 8'h52;
      default: v = 8'h54;
    endcase
    return v;
  endfunction

endpackage

// ----- design/gptc_cfg_regs.sv -----
module gptc_cfg_regs
  import gptc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  logic [1:0]  wr_index,
  input  logic [63:0] wr_data,
  output cfg_t        cfg
);

  // register writes, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.disk_sectors     <= DISK_SECTORS_RST;
      cfg.header_sector    <= PRIMARY_LBA;
      cfg.accept_stale_crc <= 1'b0;
    end else if (wr_en) begin
      case (wr_index)
        CFG_DISK_SECTORS: cfg.disk_sectors     <= wr_data;
        CFG_HEADER_LBA:   cfg.header_sector    <= wr_data;
        CFG_ALLOW_STALE:  cfg.accept_stale_crc <= wr_data[0];
        default: ;
      endcase
    end
  end

endmodule

// ----- design/gptc_core.sv -----
module gptc_core
  import gptc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    beat_valid,
  input  item_t   beat,
  input  logic    advance,
  output logic    res_valid,
  output result_t res
);

  logic [POS_W-1:0] pos;
  logic [31:0]      crc;
  logic [63:0]      field_shift;
  logic [3:0]       first_error;
  logic [31:0]      stored_hdr_crc;
  logic [31:0]      stored_ent_crc;
  logic [63:0]      entries_start;
  logic             kind;

  logic [POS_W-1:0] pos_next;
  logic [31:0]      crc_next;
  logic [63:0]      field_shift_next;
  logic [3:0]       first_error_next;
  logic [31:0]      stored_hdr_crc_next;
  logic [31:0]      stored_ent_crc_next;
  logic [63:0]      entries_start_next;

  logic             open_region;
  logic [POS_W-1:0] p;
  logic [POS_W-1:0] pos_inc;
  logic [31:0]      crc_out;
  logic [31:0]      lo;
  logic [3:0]       err_cand;
  logic [63:0]      other_lba;
  logic [63:0]      want_loc;
  logic [7:0]       crc_in;
  logic [3:0]       status;

  assign other_lba = (cfg.header_sector == PRIMARY_LBA) ? (cfg.disk_sectors - 64'd1) : 64'd1;
  assign want_loc  = (cfg.header_sector == PRIMARY_LBA) ? 64'd2 : (cfg.disk_sectors - 64'd5);

  // per-byte state update and verdict
  always_comb begin
    open_region         = (pos == '0) || (beat.action != kind);
    p                   = open_region ? '0 : pos;
    crc_next            = open_region ? CRC_INIT : crc;
    field_shift_next    = field_shift;
    first_error_next    = first_error;
    stored_hdr_crc_next = stored_hdr_crc;
    stored_ent_crc_next = stored_ent_crc;
    entries_start_next  = entries_start;
    err_cand            = ST_OK;
    lo                  = '0;
    crc_in              = beat.data_byte;

    // a fresh header drops everything learnt from the last one
    if (open_region && beat.action == ACT_HEADER) begin
      field_shift_next    = '0;
      first_error_next    = ST_OK;
      stored_hdr_crc_next = '0;
      stored_ent_crc_next = '0;
      entries_start_next  = '0;
    end

    if (beat.action == ACT_HEADER) begin
      if (p < HDR_LEN) begin
        field_shift_next = {beat.data_byte, field_shift_next[63:8]};
        lo               = field_shift_next[63:32];
        // stored header crc bytes count as zero
        if (p inside {[15'd16:15'd19]}) begin
          crc_in = 8'd0;
        end
        crc_next = crc_byte(crc_next, crc_in);
        if (p < POS_W'(8)) begin
          if (beat.data_byte != sig_byte(p[2:0])) begin
            err_cand = ST_SIGNATURE;
          end
        end
        case (p)
          15'd15: if (lo != 32'(HEADER_BYTES)) err_cand = ST_HDR_SIZE;
          15'd19: stored_hdr_crc_next = lo;
          15'd31: if (field_shift_next != cfg.header_sector) err_cand = ST_OWN_LBA;
          15'd39: if (field_shift_next != other_lba) err_cand = ST_OTHER_LBA;
          15'd47: if (field_shift_next != FIRST_USABLE) err_cand = ST_FIRST_USE;
          15'd55: begin
            if (field_shift_next != cfg.disk_sectors - FIRST_USABLE) err_cand = ST_LAST_USE;
          end
          15'd79: entries_start_next = field_shift_next;
          15'd83: if (lo != 32'(NUM_ENTRIES)) err_cand = ST_ENTRY_COUNT;
          15'd87: if (lo != 32'(ENTRY_BYTES)) err_cand = ST_ENTRY_SIZE;
          15'd91: stored_ent_crc_next = lo;
          default: ;
        endcase
        if (first_error_next == ST_OK) begin
          first_error_next = err_cand;
        end
      end
    end else begin
      crc_next = crc_byte(crc_next, beat.data_byte);
    end

    pos_inc = (p < POS_MAX) ? p + POS_W'(1) : p;
    crc_out = ~crc_next;

    // verdict for the closing beat
    if (beat.action == ACT_HEADER) begin
      if (pos_inc < HDR_LEN) begin
        status = ST_SHORT_HDR;
      end else if (first_error_next != ST_OK) begin
        status = first_error_next;
      end else if (crc_out != stored_hdr_crc_next) begin
        status = ST_HDR_CRC;
      end else if (entries_start_next != want_loc) begin
        status = ST_ENTRIES_LOC;
      end else begin
        status = ST_OK;
      end
    end else begin
      if (pos_inc != ENTRIES_LEN) begin
        status = ST_ENTRIES_LEN;
      end else if (crc_out != stored_ent_crc_next && !cfg.accept_stale_crc) begin
        status = ST_ENTRIES_CRC;
      end else begin
        status = ST_OK;
      end
    end

    pos_next = pos_inc;
    if (beat.last_byte) begin
      pos_next = '0;
      crc_next = CRC_INIT;
    end
  end

  assign res_valid            = beat_valid && beat.last_byte;
  assign res.region_done      = beat.action;
  assign res.status           = status;
  assign res.entries_location = entries_start_next;
  assign res.computed_crc     = crc_out;

  // region state
  always_ff @(posedge clk) begin
    if (rst) begin
      pos            <= '0;
      crc            <= CRC_INIT;
      field_shift    <= '0;
      first_error    <= ST_OK;
      stored_hdr_crc <= '0;
      stored_ent_crc <= '0;
      entries_start  <= '0;
      kind           <= ACT_HEADER;
    end else if (beat_valid && advance) begin
      pos            <= pos_next;
      crc            <= crc_next;
      field_shift    <= field_shift_next;
      first_error    <= first_error_next;
      stored_hdr_crc <= stored_hdr_crc_next;
      stored_ent_crc <= stored_ent_crc_next;
      entries_start  <= entries_start_next;
      kind           <= beat.action;
    end
  end

  // a closing beat leaves the region counter and crc ready for the next region
  a_close_clears : assert property (@(posedge clk) disable iff (rst)
    beat_valid && advance && beat.last_byte |=> pos == '0 && crc == CRC_INIT)
    else $error("region state not cleared after closing beat");

  // header verdicts never carry entry-array codes
  a_hdr_codes : assert property (@(posedge clk) disable iff (rst)
    res_valid && beat.action == ACT_HEADER |->
      res.status != ST_ENTRIES_CRC && res.status != ST_ENTRIES_LEN)
    else $error("entry-array code on header verdict");

  // entry verdicts only carry ok, crc or length codes
  a_ent_codes : assert property (@(posedge clk) disable iff (rst)
    res_valid && beat.action == ACT_ENTRIES |->
      res.status == ST_OK || res.status == ST_ENTRIES_CRC || res.status == ST_ENTRIES_LEN)
    else $error("header code on entry-array verdict");

  // region kind follows each accepted beat
  a_kind_follows : assert property (@(posedge clk) disable iff (rst)
    beat_valid && advance |=> kind == $past(beat.action))
    else $error("region kind does not follow accepted beat");

endmodule

// ----- design/gpt_header_and_entries_checker.sv -----
// channel | direction | handshake          | payload
// item    | in        | item_valid/stall   | item_t: action, data_byte, last_byte
// result  | out       | result_valid/stall | result_t: region_done, status, location, crc
// cfg     | in        | cfg_valid/ready    | cfg_index (2 bits), cfg_data (64 bits)
//
// one byte a cycle sustained, unless a closing beat waits on a stalled result
// path: input register, byte-wide crc update and field compare, result register
// rst is synchronous; it restores register defaults and an empty region
// result_stall holds the result register; the input register stalls only when
// it holds a closing beat that cannot yet move into a full result register
module gpt_header_and_entries_checker
  import gptc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  item_t       item,
  output logic        result_valid,
  input  logic        result_stall,
  output result_t     result,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  cfg_t    cfg;
  item_t   item_q;
  logic    item_q_valid;
  logic    advance;
  logic    res_valid;
  result_t res;

  assign cfg_ready = 1'b1;

  gptc_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // the held beat moves on unless it would overwrite a waiting result
  assign advance    = !(item_q_valid && item_q.last_byte && result_valid && result_stall);
  assign item_stall = item_q_valid && !advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_q_valid <= 1'b0;
    end else if (!item_stall) begin
      item_q_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!item_stall && item_valid) begin
      item_q <= item;
    end
  end

  gptc_core u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .beat_valid (item_q_valid),
    .beat       (item_q),
    .advance    (advance),
    .res_valid  (res_valid),
    .res        (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (res_valid && advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && advance) begin
      result <= res;
    end
  end

endmodule
